// ----- hw/rtl/psue_pkg.sv -----
// Shared types, sizes and codes for the particle swarm update engine.
// No dependencies; psue_front, psue_back, the top level and the testbench import it.
package psue_pkg;

	localparam int MAX_PARTICLES = 64;
	localparam int MAX_DIMS      = 16;
	localparam int ELEMS         = MAX_PARTICLES * MAX_DIMS;
	localparam int PW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int EW  = (ELEMS > 1) ? $clog2(ELEMS) : 1;
	localparam int NDW = $clog2(MAX_DIMS + 1);

	localparam logic signed [31:0] FIT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FIT_MIN = 32'sh8000_0000;

	localparam logic [2:0] ACT_BOUNDS = 3'd0;
	localparam logic [2:0] ACT_INIT   = 3'd1;
	localparam logic [2:0] ACT_UPDATE = 3'd2;
	localparam logic [2:0] ACT_REPORT = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;
	localparam logic [2:0] ACT_START  = 3'd5;

	localparam logic [2:0] CFG_SELF   = 3'd0;
	localparam logic [2:0] CFG_SWARM  = 3'd1;
	localparam logic [2:0] CFG_ISTART = 3'd2;
	localparam logic [2:0] CFG_ISLOPE = 3'd3;
	localparam logic [2:0] CFG_MUT    = 3'd4;
	localparam logic [2:0] CFG_NPART  = 3'd5;
	localparam logic [2:0] CFG_NDIM   = 3'd6;

	// decoded operations after range checks
	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_BOUNDS = 3'd1;
	localparam logic [2:0] OP_INIT   = 3'd2;
	localparam logic [2:0] OP_UPDATE = 3'd3;
	localparam logic [2:0] OP_REPORT = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;
	localparam logic [2:0] OP_START  = 3'd6;

	typedef struct packed {
		logic [2:0]         action;
		logic [5:0]         particle;
		logic [3:0]         dimension;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic [15:0]        draw_self;
		logic [15:0]        draw_swarm;
		logic [15:0]        draw_mutate;
		logic [15:0]        draw_reset;
		logic [15:0]        iteration;
		logic               first_report;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] position_out;
		logic signed [31:0] best_fitness;
		logic               personal_improved;
		logic               global_improved;
		logic               hit_lower;
		logic               hit_upper;
		logic               mutated;
	} result_t;

	typedef struct packed {
		logic [15:0]        self_confidence;
		logic [15:0]        swarm_confidence;
		logic signed [15:0] inertia_start;
		logic signed [31:0] inertia_slope;
		logic [15:0]        mutation_threshold;
		logic [6:0]         particles_in_use;
		logic [4:0]         dims_in_use;
	} cfg_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [PW-1:0]      p;
		logic [DW-1:0]      d;
		logic [EW-1:0]      e;
		logic signed [31:0] va;
		logic signed [31:0] vb;
		logic [15:0]        draw_self;
		logic [15:0]        draw_swarm;
		logic [15:0]        draw_mutate;
		logic [15:0]        draw_reset;
		logic [15:0]        iter;
		logic               first;
	} item_t;

endpackage

// ----- hw/rtl/psue_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psue_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hw/rtl/psue_front.sv -----
// Front end: accepts commands, range-checks and decodes them, queues them.
// Depends on psue_pkg.
module psue_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  psue_pkg::cmd_t   cmd,
	input  psue_pkg::cfg_t   cfg,
	input  logic             pop,
	output psue_pkg::item_t  head,
	output logic             head_valid
);
	import psue_pkg::*;

	localparam int QD = 2;

	item_t      cls;
	item_t      slot_q [QD];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push, p_use, d_use, d_ok;

	always_comb begin
		p_use = (32'(cmd.particle) < 32'(cfg.particles_in_use)) &&
			(32'(cmd.particle) < 32'(MAX_PARTICLES));
		d_ok  = 32'(cmd.dimension) < 32'(MAX_DIMS);
		d_use = d_ok && (32'(cmd.dimension) < 32'(cfg.dims_in_use));
		cls.p           = PW'(cmd.particle);
		cls.d           = DW'(cmd.dimension);
		cls.e           = EW'(32'(cmd.particle) * MAX_DIMS + 32'(cmd.dimension));
		cls.va          = cmd.value_a;
		cls.vb          = cmd.value_b;
		cls.draw_self   = cmd.draw_self;
		cls.draw_swarm  = cmd.draw_swarm;
		cls.draw_mutate = cmd.draw_mutate;
		cls.draw_reset  = cmd.draw_reset;
		cls.iter        = cmd.iteration;
		cls.first       = cmd.first_report;
		case (cmd.action)
			ACT_BOUNDS: cls.op = d_ok ? OP_BOUNDS : OP_NOP;
			ACT_INIT:   cls.op = (p_use && d_use) ? OP_INIT : OP_NOP;
			ACT_UPDATE: cls.op = (p_use && d_use) ? OP_UPDATE : OP_NOP;
			ACT_REPORT: cls.op = p_use ? OP_REPORT : OP_NOP;
			ACT_READ:   cls.op = d_ok ? OP_READ : OP_NOP;
			ACT_START:  cls.op = OP_START;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign busy       = (cnt_q == 2'(QD));
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot_q[rd_q];
	assign push       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end
endmodule

// ----- hw/rtl/psue_back.sv -----
// Back end: executes decoded items against the swarm stores, one at a time.
// Depends on psue_pkg and psue_ram.
module psue_back (
	input  logic              clk,
	input  logic              arst_n,
	input  psue_pkg::item_t   head,
	input  logic              head_valid,
	output logic              pop,
	input  psue_pkg::cfg_t    cfg,
	output logic              done,
	output psue_pkg::result_t result
);
	import psue_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_WB   = 3'd4;
	localparam logic [2:0] ST_FCMP = 3'd5;
	localparam logic [2:0] ST_COPY = 3'd6;

	logic [2:0] state_q;
	item_t      cur_q;

	logic signed [31:0] gfit_q;
	logic signed [31:0] gbest_q [MAX_DIMS];
	logic signed [31:0] lo_q [MAX_DIMS];
	logic signed [31:0] hi_q [MAX_DIMS];

	logic               done_q, o_pimp_q, o_gimp_q, o_lo_q, o_hi_q, o_mut_q;
	logic signed [31:0] o_pos_q;

	// update datapath registers
	logic signed [48:0] wraw_s1;
	logic [19:0]        cs_s1, cw_s1;
	logic signed [31:0] lo_s1, hi_s1, gb_s1;
	logic               mut_s1;
	logic signed [47:0] ti_s2;
	logic signed [53:0] ts_s2, tg_s2;
	logic signed [49:0] mp_s2;
	logic signed [31:0] x_s2;
	logic signed [31:0] nv_s3;

	// report / copy control
	logic             pimp_q, gimp_q, kdv_q;
	logic [NDW-1:0]   k_q, kd_q, nd;
	logic [EW-1:0]    base;

	// RAM ports
	logic             pos_we, vel_we, pb_we, pf_we;
	logic [EW-1:0]    pos_ra, pb_wa;
	logic [31:0]      pos_wd, vel_wd, pb_wd, pos_rd, vel_rd, pb_rd, pf_rd;

	// combinational datapath
	logic signed [48:0] sl_prod;
	logic signed [32:0] w_fl, diff_s, diff_g, nx, span;
	logic signed [15:0] w_sat;
	logic signed [49:0] nv_full;
	logic signed [31:0] nv_neg, mpos, upd_pos, upd_vel;
	logic               lt, gt, c_pimp, c_gimp;

	assign pop  = (state_q == ST_IDLE) && head_valid;
	assign base = EW'(32'(cur_q.p) * MAX_DIMS);
	assign nd   = (32'(cfg.dims_in_use) > 32'(MAX_DIMS)) ? NDW'(MAX_DIMS)
		: NDW'(cfg.dims_in_use);

	always_comb begin
		sl_prod = cfg.inertia_slope * $signed({1'b0, cur_q.iter});
		w_fl    = 33'(wraw_s1 >>> 16);
		if (w_fl > 33'sd32767) begin
			w_sat = 16'sh7FFF;
		end else if (w_fl < -33'sd32768) begin
			w_sat = 16'sh8000;
		end else begin
			w_sat = w_fl[15:0];
		end
		diff_s = 33'($signed(pb_rd)) - 33'($signed(pos_rd));
		diff_g = 33'(gb_s1) - 33'($signed(pos_rd));
		span   = 33'(hi_s1) - 33'(lo_s1);
		nv_full = 50'(ti_s2 >>> 12) + 50'(ts_s2 >>> 16) + 50'(tg_s2 >>> 16);
		nx      = 33'(x_s2) + 33'(nv_s3);
		lt      = nx < 33'(lo_s1);
		gt      = !lt && (nx > 33'(hi_s1));
		nv_neg  = (nv_s3 == FIT_MIN) ? FIT_MAX : -nv_s3;
		mpos    = 32'(34'(lo_s1) + 34'(mp_s2 >>> 16));
		if (mut_s1) begin
			upd_pos = mpos;
		end else if (lt) begin
			upd_pos = lo_s1;
		end else if (gt) begin
			upd_pos = hi_s1;
		end else begin
			upd_pos = nx[31:0];
		end
		upd_vel = (lt || gt) ? nv_neg : nv_s3;
		c_pimp  = cur_q.first || (cur_q.va < $signed(pf_rd));
		c_gimp  = cur_q.va < gfit_q;
	end

	// RAM port muxing
	always_comb begin
		pos_we = 1'b0;
		vel_we = 1'b0;
		pb_we  = 1'b0;
		pf_we  = 1'b0;
		pos_wd = cur_q.va;
		vel_wd = 32'd0;
		pb_wd  = cur_q.va;
		pb_wa  = cur_q.e;
		pos_ra = (state_q == ST_COPY) ? base + EW'(k_q) : cur_q.e;
		case (state_q)
			ST_EXEC: begin
				if (cur_q.op == OP_INIT) begin
					pos_we = 1'b1;
					vel_we = 1'b1;
					pb_we  = 1'b1;
				end
			end
			ST_WB: begin
				pos_we = 1'b1;
				vel_we = 1'b1;
				pos_wd = upd_pos;
				vel_wd = upd_vel;
			end
			ST_FCMP: pf_we = c_pimp;
			ST_COPY: begin
				pb_we = kdv_q && pimp_q;
				pb_wd = pos_rd;
				pb_wa = base + EW'(kd_q);
			end
			default: ;
		endcase
	end

	psue_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_pos (
		.clk(clk), .we(pos_we), .waddr(cur_q.e), .wdata(pos_wd),
		.raddr(pos_ra), .rdata(pos_rd)
	);
	psue_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_vel (
		.clk(clk), .we(vel_we), .waddr(cur_q.e), .wdata(vel_wd),
		.raddr(cur_q.e), .rdata(vel_rd)
	);
	psue_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_pbest (
		.clk(clk), .we(pb_we), .waddr(pb_wa), .wdata(pb_wd),
		.raddr(cur_q.e), .rdata(pb_rd)
	);
	psue_ram #(.WIDTH(32), .DEPTH(MAX_PARTICLES)) u_pfit (
		.clk(clk), .we(pf_we), .waddr(cur_q.p), .wdata(cur_q.va),
		.raddr(cur_q.p), .rdata(pf_rd)
	);

	// payload pipeline
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == ST_EXEC && cur_q.op == OP_BOUNDS) begin
			lo_q[cur_q.d] <= cur_q.va;
			hi_q[cur_q.d] <= cur_q.vb;
		end
		if (state_q == ST_EXEC) begin
			wraw_s1 <= (49'(cfg.inertia_start) <<< 16) + sl_prod;
			cs_s1   <= 20'((32'(cur_q.draw_self) * 32'(cfg.self_confidence)) >> 12);
			cw_s1   <= 20'((32'(cur_q.draw_swarm) * 32'(cfg.swarm_confidence)) >> 12);
			lo_s1   <= lo_q[cur_q.d];
			hi_s1   <= hi_q[cur_q.d];
			gb_s1   <= gbest_q[cur_q.d];
			mut_s1  <= cur_q.draw_mutate < cfg.mutation_threshold;
		end
		if (state_q == ST_MUL) begin
			ti_s2 <= 48'(w_sat) * 48'($signed(vel_rd));
			ts_s2 <= 54'($signed({1'b0, cs_s1})) * 54'(diff_s);
			tg_s2 <= 54'($signed({1'b0, cw_s1})) * 54'(diff_g);
			mp_s2 <= 50'(span) * 50'($signed({1'b0, cur_q.draw_reset}));
			x_s2  <= $signed(pos_rd);
		end
		if (state_q == ST_SUM) begin
			if (nv_full > 50'(FIT_MAX)) begin
				nv_s3 <= FIT_MAX;
			end else if (nv_full < 50'(FIT_MIN)) begin
				nv_s3 <= FIT_MIN;
			end else begin
				nv_s3 <= nv_full[31:0];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			gfit_q   <= FIT_MAX;
			for (int i = 0; i < MAX_DIMS; i++) begin
				gbest_q[i] <= 32'sd0;
			end
			o_pos_q  <= 32'sd0;
			o_pimp_q <= 1'b0;
			o_gimp_q <= 1'b0;
			o_lo_q   <= 1'b0;
			o_hi_q   <= 1'b0;
			o_mut_q  <= 1'b0;
			pimp_q   <= 1'b0;
			gimp_q   <= 1'b0;
			kdv_q    <= 1'b0;
			k_q      <= '0;
			kd_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					o_pos_q  <= 32'sd0;
					o_pimp_q <= 1'b0;
					o_gimp_q <= 1'b0;
					o_lo_q   <= 1'b0;
					o_hi_q   <= 1'b0;
					o_mut_q  <= 1'b0;
					case (cur_q.op)
						OP_UPDATE: state_q <= ST_MUL;
						OP_REPORT: state_q <= ST_FCMP;
						OP_INIT: begin
							o_pos_q <= cur_q.va;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						OP_READ: begin
							o_pos_q <= gbest_q[cur_q.d];
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						OP_START: begin
							gfit_q <= FIT_MAX;
							for (int i = 0; i < MAX_DIMS; i++) begin
								gbest_q[i] <= 32'sd0;
							end
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_WB;
				ST_WB: begin
					o_pos_q <= upd_pos;
					o_lo_q  <= lt;
					o_hi_q  <= gt;
					o_mut_q <= mut_s1;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FCMP: begin
					pimp_q   <= c_pimp;
					gimp_q   <= c_gimp;
					o_pimp_q <= c_pimp;
					o_gimp_q <= c_gimp;
					if (c_gimp) begin
						gfit_q <= cur_q.va;
					end
					k_q   <= '0;
					kdv_q <= 1'b0;
					if (c_pimp || c_gimp) begin
						state_q <= ST_COPY;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					// read of component k overlaps the write of component k-1
					if (kdv_q && gimp_q) begin
						gbest_q[kd_q[DW-1:0]] <= $signed(pos_rd);
					end
					if (k_q < nd) begin
						kd_q  <= k_q;
						kdv_q <= 1'b1;
						k_q   <= k_q + NDW'(1);
					end else begin
						kdv_q <= 1'b0;
						if (!kdv_q) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	always_comb begin
		result.position_out      = o_pos_q;
		result.best_fitness      = gfit_q;
		result.personal_improved = o_pimp_q;
		result.global_improved   = o_gimp_q;
		result.hit_lower         = o_lo_q;
		result.hit_upper         = o_hi_q;
		result.mutated           = o_mut_q;
	end
endmodule

// ----- hw/rtl/particle_swarm_update_engine_core.sv -----
// Top level of the particle swarm update engine: configuration registers,
// front end, back end. Depends on psue_pkg, psue_front, psue_back, psue_ram.
//
// Usage:
//  A command transaction is taken when start is high and busy is low. The
//  front end decodes it into a two-entry queue; busy rises only when that
//  queue is full. Every command yields exactly one result, shown on result
//  for one cycle with done high; the receiver cannot stall it.
//  Steps per command: set bounds, init, read best, start run and ignored
//  commands finish in the execute state; an element update goes through
//  read, multiply, sum and write back via the position/velocity RAMs and
//  two multiplier stages; a fitness report compares the fitness, then,
//  when a best is replaced, copies the in-use components one per cycle
//  through the position RAM port. Commands run one at a time in the
//  back end, which takes the next queued command only once idle again.
//  Configuration through cfg_we, cfg_idx, cfg_wdata is to be written by
//  the user only while the block is idle; the block itself does not
//  enforce this. Reset restores register defaults, empties the queue,
//  sets the global best fitness to the maximum and its position to zero;
//  swarm memories are not cleared.
module particle_swarm_update_engine_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psue_pkg::cmd_t    cmd,
	output logic              done,
	output psue_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_idx,
	input  logic [31:0]       cfg_wdata
);
	import psue_pkg::*;

	cfg_t  cfg_q;
	item_t head;
	logic  head_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_confidence    <= 16'd4096;
			cfg_q.swarm_confidence   <= 16'd8192;
			cfg_q.inertia_start      <= 16'sd2048;
			cfg_q.inertia_slope      <= 32'sd0;
			cfg_q.mutation_threshold <= 16'd655;
			cfg_q.particles_in_use   <= 7'd64;
			cfg_q.dims_in_use        <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SELF:   cfg_q.self_confidence    <= cfg_wdata[15:0];
				CFG_SWARM:  cfg_q.swarm_confidence   <= cfg_wdata[15:0];
				CFG_ISTART: cfg_q.inertia_start      <= cfg_wdata[15:0];
				CFG_ISLOPE: cfg_q.inertia_slope      <= cfg_wdata;
				CFG_MUT:    cfg_q.mutation_threshold <= cfg_wdata[15:0];
				CFG_NPART:  cfg_q.particles_in_use   <= cfg_wdata[6:0];
				CFG_NDIM:   cfg_q.dims_in_use        <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	psue_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg(cfg_q), .pop(pop), .head(head), .head_valid(head_valid)
	);

	psue_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .head_valid(head_valid),
		.pop(pop), .cfg(cfg_q), .done(done), .result(result)
	);

	// two results never leave the back end back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back done");

	a_clamp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.hit_lower && result.hit_upper))
		else $error("both clamp flags set");

	a_flag_mix: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.personal_improved || result.global_improved) |->
		!(result.hit_lower || result.hit_upper || result.mutated))
		else $error("report and update flags mixed");

	// a pop requires a queued entry
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
endmodule

// ----- tb/sv/particle_swarm_update_engine_core_tb.sv -----
// Self-checking testbench for particle_swarm_update_engine_core: directed and random
// command transactions, checked against a behavioral predictor of the swarm state.
// Depends on psue_pkg and the engine RTL.
`timescale 1ns / 100ps

module particle_swarm_update_engine_core_tb;
	import psue_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 5000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	particle_swarm_update_engine_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// swarm state mirror
	longint sw_pos[ELEMS];
	longint sw_vel[ELEMS];
	longint sw_pbest[ELEMS];
	longint sw_pfit[MAX_PARTICLES];
	longint sw_gpos[MAX_DIMS];
	longint sw_gfit;
	longint sw_lo[MAX_DIMS];
	longint sw_hi[MAX_DIMS];
	bit     elem_ok[ELEMS];
	bit     pfit_ok[MAX_PARTICLES];
	bit     bnd_ok[MAX_DIMS];
	cfg_t   regs;

	result_t expected_results[$];
	int      mismatches;
	int      stall_cycles;
	bit      gaps_on;

	function automatic longint clip32(longint v);
		if (v < -64'sd2147483648) return -64'sd2147483648;
		if (v > 64'sd2147483647) return 64'sd2147483647;
		return v;
	endfunction

	function automatic int n_part();
		return (regs.particles_in_use > MAX_PARTICLES) ? MAX_PARTICLES : regs.particles_in_use;
	endfunction

	function automatic int n_dim();
		return (regs.dims_in_use > MAX_DIMS) ? MAX_DIMS : regs.dims_in_use;
	endfunction

	function automatic result_t swarm_step(cmd_t c);
		result_t r;
		int      np, nd, e, b;
		longint  x, v, lo, hi, w, cs, cw, nv, nx, va;
		np = n_part();
		nd = n_dim();
		r = '0;
		va = longint'(c.value_a);
		case (c.action)
			ACT_BOUNDS: begin
				sw_lo[c.dimension] = va;
				sw_hi[c.dimension] = longint'(c.value_b);
				bnd_ok[c.dimension] = 1'b1;
			end
			ACT_INIT: if (c.particle < np && c.dimension < nd) begin
				e = c.particle * MAX_DIMS + c.dimension;
				sw_pos[e] = va;
				sw_pbest[e] = va;
				sw_vel[e] = 0;
				elem_ok[e] = 1'b1;
				r.position_out = c.value_a;
			end
			ACT_UPDATE: if (c.particle < np && c.dimension < nd) begin
				e = c.particle * MAX_DIMS + c.dimension;
				x = sw_pos[e];
				v = sw_vel[e];
				lo = sw_lo[c.dimension];
				hi = sw_hi[c.dimension];
				w = longint'(regs.inertia_start) * 65536
					+ longint'(regs.inertia_slope) * longint'(c.iteration);
				w = w >>> 16;
				if (w < -32768) w = -32768;
				if (w > 32767) w = 32767;
				cs = (longint'(c.draw_self) * longint'(regs.self_confidence)) >>> 12;
				cw = (longint'(c.draw_swarm) * longint'(regs.swarm_confidence)) >>> 12;
				nv = ((w * v) >>> 12) + ((cs * (sw_pbest[e] - x)) >>> 16)
					+ ((cw * (sw_gpos[c.dimension] - x)) >>> 16);
				nv = clip32(nv);
				nx = x + nv;
				if (nx < lo) begin
					nx = lo;
					r.hit_lower = 1'b1;
					nv = clip32(-nv);
				end else if (nx > hi) begin
					nx = hi;
					r.hit_upper = 1'b1;
					nv = clip32(-nv);
				end
				if (c.draw_mutate < regs.mutation_threshold) begin
					nx = lo + (((hi - lo) * longint'(c.draw_reset)) >>> 16);
					r.mutated = 1'b1;
				end
				sw_pos[e] = nx;
				sw_vel[e] = nv;
				r.position_out = nx[31:0];
			end
			ACT_REPORT: if (c.particle < np) begin
				b = c.particle * MAX_DIMS;
				if (c.first_report || va < sw_pfit[c.particle]) begin
					sw_pfit[c.particle] = va;
					pfit_ok[c.particle] = 1'b1;
					for (int k = 0; k < nd; k++) sw_pbest[b + k] = sw_pos[b + k];
					r.personal_improved = 1'b1;
				end
				if (va < sw_gfit) begin
					sw_gfit = va;
					for (int k = 0; k < nd; k++) sw_gpos[k] = sw_pos[b + k];
					r.global_improved = 1'b1;
				end
			end
			ACT_READ: r.position_out = sw_gpos[c.dimension][31:0];
			ACT_START: begin
				sw_gfit = 64'sd2147483647;
				foreach (sw_gpos[k]) sw_gpos[k] = 0;
			end
			default: ;
		endcase
		r.best_fitness = sw_gfit[31:0];
		return r;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %p", result);
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch at %0t: expected %p, got %p", $time, want, result);
				end
			end
		end
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(cmd_t c);
		bit was_busy;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		forever begin
			was_busy = busy;
			@(posedge clk);
			if (!was_busy) break;
			@(negedge clk);
		end
		expected_results.push_back(swarm_step(c));
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_results.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		drain();
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_SELF:   regs.self_confidence = val[15:0];
			CFG_SWARM:  regs.swarm_confidence = val[15:0];
			CFG_ISTART: regs.inertia_start = val[15:0];
			CFG_ISLOPE: regs.inertia_slope = val;
			CFG_MUT:    regs.mutation_threshold = val[15:0];
			CFG_NPART:  regs.particles_in_use = val[6:0];
			CFG_NDIM:   regs.dims_in_use = val[4:0];
			default: ;
		endcase
	endtask

	function automatic cmd_t make_cmd(logic [2:0] act, int p, int d, logic [31:0] va,
			logic [31:0] vb);
		cmd_t c;
		c = '0;
		c.action = act;
		c.particle = 6'(p);
		c.dimension = 4'(d);
		c.value_a = va;
		c.value_b = vb;
		c.draw_self = 16'($urandom);
		c.draw_swarm = 16'($urandom);
		c.draw_mutate = 16'($urandom);
		c.draw_reset = 16'($urandom);
		c.iteration = 16'($urandom);
		c.first_report = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000;
		endcase
	endfunction

	// picks a transaction that never touches an unwritten store entry
	function automatic cmd_t legal_cmd();
		cmd_t c;
		int   np, nd, p, d, sel, e, lo;
		np = n_part();
		nd = n_dim();
		p = $urandom_range(0, np - 1);
		d = $urandom_range(0, nd - 1);
		e = p * MAX_DIMS + d;
		sel = $urandom_range(0, 99);
		c = make_cmd(ACT_READ, p, d, rand_value(), rand_value());
		if (sel < 10) begin
			c.action = ACT_BOUNDS;
			c.dimension = 4'($urandom_range(0, MAX_DIMS - 1));
			if ($urandom_range(0, 9) != 0) begin
				lo = $urandom_range(0, 32'h0040_0000);
				c.value_a = -lo;
				c.value_b = lo + $urandom_range(0, 32'h0004_0000);
			end
		end else if (sel < 20 || (sel < 62 && (!elem_ok[e] || !bnd_ok[d]))) begin
			c.action = ACT_INIT;
			if (!bnd_ok[d]) begin
				c.action = ACT_BOUNDS;
				c.value_a = -32'sd1 * $urandom_range(0, 32'h0040_0000);
				c.value_b = $urandom_range(0, 32'h0040_0000);
			end
		end else if (sel < 62) begin
			c.action = ACT_UPDATE;
			if ($urandom_range(0, 3) == 0) c.draw_mutate = 16'($urandom_range(0, 1500));
		end else if (sel < 78) begin
			c.action = ACT_REPORT;
			if (!pfit_ok[p]) c.first_report = 1'b1;
			else if ($urandom_range(0, 3) != 0) c.first_report = 1'b0;
			for (int k = 0; k < nd; k++)
				if (!elem_ok[p * MAX_DIMS + k]) begin
					c.action = ACT_INIT;
					c.dimension = 4'(k);
					break;
				end
		end else if (sel < 88) begin
			c.dimension = 4'($urandom);
		end else if (sel < 91) begin
			c.action = ACT_START;
		end else if (sel < 95) begin
			c.action = 3'($urandom_range(6, 7));
			c.particle = 6'($urandom);
			c.dimension = 4'($urandom);
		end else begin
			// element out of use
			c.action = 3'($urandom_range(ACT_INIT, ACT_REPORT));
			c.particle = 6'($urandom);
			c.dimension = 4'($urandom);
			if (c.particle < np && c.dimension < nd)
				c.particle = (np < MAX_PARTICLES) ? 6'(np) : c.particle;
			if (c.particle < np && c.dimension < nd) c.action = ACT_READ;
			if (c.action == ACT_REPORT && c.particle < np) c.action = ACT_READ;
		end
		return c;
	endfunction

	task automatic test_directed();
		cmd_t c;
		write_reg(CFG_NDIM, 32'd2);
		send(make_cmd(ACT_BOUNDS, 0, 0, FIT_MIN, FIT_MAX));
		send(make_cmd(ACT_BOUNDS, 0, 1, 32'sh0001_0000, -32'sh0001_0000));
		send(make_cmd(ACT_BOUNDS, 0, 15, FIT_MAX, FIT_MIN));
		send(make_cmd(ACT_INIT, 0, 0, FIT_MAX, 0));
		send(make_cmd(ACT_INIT, 0, 1, FIT_MIN, 0));
		send(make_cmd(ACT_INIT, 63, 0, 32'sh0000_8000, 0));
		send(make_cmd(ACT_INIT, 63, 1, -32'sh0002_0000, 0));
		send(make_cmd(ACT_INIT, 63, 15, 0, 0));
		c = make_cmd(ACT_REPORT, 0, 0, FIT_MAX, 0);
		c.first_report = 1'b1;
		send(c);
		c = make_cmd(ACT_REPORT, 63, 0, FIT_MIN, 0);
		c.first_report = 1'b1;
		send(c);
		c = make_cmd(ACT_UPDATE, 0, 0, 0, 0);
		c.draw_self = 16'hFFFF; c.draw_swarm = 16'hFFFF; c.draw_mutate = 16'hFFFF;
		c.iteration = 16'hFFFF;
		send(c);
		c = make_cmd(ACT_UPDATE, 63, 1, 0, 0);
		c.draw_mutate = 0; c.draw_reset = 16'hFFFF;
		send(c);
		c = make_cmd(ACT_UPDATE, 0, 1, 0, 0);
		c.draw_mutate = 0; c.draw_reset = 0;
		send(c);
		c = make_cmd(ACT_REPORT, 0, 0, FIT_MIN, 0);
		c.first_report = 1'b0;
		send(c);
		send(make_cmd(ACT_READ, 0, 0, 0, 0));
		send(make_cmd(ACT_READ, 0, 15, 0, 0));
		send(make_cmd(ACT_START, 0, 0, 0, 0));
		send(make_cmd(ACT_READ, 0, 1, 0, 0));
		send(make_cmd(ACT_INIT, 5, 2, 32'sh1234_5678, 0));
		send(make_cmd(3'd6, 63, 15, FIT_MAX, FIT_MIN));
		send(make_cmd(3'd7, 0, 0, 0, 0));
	endtask

	task automatic test_pressure();
		for (int i = 0; i < 30; i++) send(legal_cmd());
		// hold off the sender until everything outstanding is back
		while (expected_results.size() != 0) @(negedge clk);
		for (int i = 0; i < 30; i++) send(legal_cmd());
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			write_reg(CFG_SELF, (ph == 0) ? 32'hFFFF : (ph == 1) ? 32'd0 : $urandom_range(0, 16'hFFFF));
			write_reg(CFG_SWARM, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF : $urandom_range(0, 16'hFFFF));
			write_reg(CFG_ISTART, (ph == 0) ? 32'h7FFF : (ph == 1) ? 32'h8000 : $urandom);
			write_reg(CFG_ISLOPE, (ph == 0) ? 32'h8000_0000 : (ph == 1) ? 32'h7FFF_FFFF
				: (ph == 2) ? 32'd0 : $urandom);
			write_reg(CFG_MUT, (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF : $urandom_range(0, 16'h2000));
			write_reg(CFG_NPART, (ph == 0) ? 32'd1 : (ph == 1) ? 32'd64 : $urandom_range(1, 10));
			write_reg(CFG_NDIM, (ph == 0) ? 32'd16 : (ph == 1) ? 32'd1 : $urandom_range(1, 5));
			if (ph == phases - 1) gaps_on = 1'b0;
			for (int i = 0; i < per_phase; i++) send(legal_cmd());
		end
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_SELF;
		cfg_wdata = '0;
		mismatches = 0;
		stall_cycles = 0;
		gaps_on = 1'b1;
		regs.self_confidence = 16'd4096;
		regs.swarm_confidence = 16'd8192;
		regs.inertia_start = 16'sd2048;
		regs.inertia_slope = 32'sd0;
		regs.mutation_threshold = 16'd655;
		regs.particles_in_use = 7'd64;
		regs.dims_in_use = 5'd16;
		sw_gfit = 64'sd2147483647;
		foreach (sw_gpos[k]) sw_gpos[k] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_pressure();
		test_random(10, 115);

		guard = 0;
		while (expected_results.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- particle_swarm_update_engine_core.f -----
hw/rtl/psue_pkg.sv
hw/rtl/psue_ram.sv
hw/rtl/psue_front.sv
hw/rtl/psue_back.sv
hw/rtl/particle_swarm_update_engine_core.sv
tb/sv/particle_swarm_update_engine_core_tb.sv
